// ----- rtl/nclbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// nclbsd_pkg: shared types and constants for the line blank strip filter
// Holds the scan mode encoding, the status codes of end words and the
// record that carries one step result from the decoder to the top level.
// ----------------------------------------------------------------------------
package nclbsd_pkg;

    // Scan mode of the current line.
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_PAREN   = 2'd1,
        MODE_SEMI    = 2'd2,
        MODE_DISCARD = 2'd3
    } scan_mode_t;

    // Status codes carried on end and error words.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NESTED   = 2'd1,
        ST_UNCLOSED = 2'd2,
        ST_NEWLINE  = 2'd3
    } status_t;

    // Character codes that steer the scan.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UPPER_LO = 8'd64;  // exclusive lower bound of 'A'..'Z'
    localparam logic [7:0] CH_UPPER_HI = 8'd91;  // exclusive upper bound
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // One step result: whether a word is produced and its fields.
    typedef struct packed {
        logic       emit;
        logic [7:0] char_out;
        logic       line_end;
        status_t    status;
    } step_res_t;

endpackage

// ----- rtl/nc_line_blank_strip_downcase.sv -----
// ----------------------------------------------------------------------------
// nc_line_blank_strip_downcase: machine-tool code line filter
// Strips blanks and lower-cases letters outside comments, passes comments
// literally and reports line end or syntax errors on a closing word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one raw character per word in s_tdata; a zero byte
//   ends the line. Master channel m_*: one filtered character per word, or a
//   closing word with m_tlast high, m_tdata zero and the status in m_tuser
//   (0 ok, 1 nested comment, 2 unclosed comment, 3 newline not last).
//   Blanks outside comments, a newline before the terminator and everything
//   after an error up to and including the terminator produce no word.
//   A word accepted at a clock edge appears on the master side after that
//   edge. Throughput is one character per cycle while the master side does
//   not stall; the scan state update and the output register set this rate.
//   The output register takes a new word in the same cycle that the old one
//   is drained, so s_tready is low only while m_tvalid is high and m_tready
//   low. A stalled receiver therefore holds the input back by one word.
//   Reset (aresetn low at a clock edge) empties the output register and
//   returns the scan to normal text with no newline pending.
// ----------------------------------------------------------------------------
module nc_line_blank_strip_downcase (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast,   // line_end
    output logic [1:0] m_tuser    // [1:0] status
);

    nclbsd_pkg::scan_mode_t mode_reg, mode_next;
    logic                   pending_reg, pending_next;
    nclbsd_pkg::step_res_t  step_res;
    logic                   s_accept;

    logic                   m_tvalid_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;
    nclbsd_pkg::status_t    status_reg;

    // Accept whenever the output register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Decode of the incoming word.
    nclbsd_step u_step (
        .mode            (mode_reg),
        .newline_pending (pending_reg),
        .char_in         (s_tdata),
        .res             (step_res),
        .mode_next       (mode_next),
        .pending_next    (pending_next)
    );

    // Scan state advances on every accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= nclbsd_pkg::MODE_NORMAL;
            pending_reg <= 1'b0;
        end else if (s_accept) begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept && step_res.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload, loaded with each produced word.
    always_ff @(posedge aclk) begin
        if (s_accept && step_res.emit) begin
            char_reg   <= step_res.char_out;
            last_reg   <= step_res.line_end;
            status_reg <= step_res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

endmodule

// ----- rtl/nclbsd_step.sv -----
// ----------------------------------------------------------------------------
// nclbsd_step: one character step of the line filter
// Purely combinational: from the current scan state and one character it
// works out the result word, if any, and the next scan state.
// ----------------------------------------------------------------------------
module nclbsd_step (
    input  nclbsd_pkg::scan_mode_t mode,
    input  logic                   newline_pending,
    input  logic [7:0]             char_in,
    output nclbsd_pkg::step_res_t  res,
    output nclbsd_pkg::scan_mode_t mode_next,
    output logic                   pending_next
);

    logic is_nul;
    logic is_blank;
    logic is_upper;

    assign is_nul   = (char_in == nclbsd_pkg::CH_NUL);
    assign is_blank = (char_in == nclbsd_pkg::CH_SPACE) || (char_in == nclbsd_pkg::CH_TAB)
                   || (char_in == nclbsd_pkg::CH_CR);
    assign is_upper = (char_in > nclbsd_pkg::CH_UPPER_LO) && (char_in < nclbsd_pkg::CH_UPPER_HI);

    // Decode the character against the current mode; order follows priority.
    always_comb begin
        res.emit     = 1'b0;
        res.char_out = char_in;
        res.line_end = 1'b0;
        res.status   = nclbsd_pkg::ST_OK;
        mode_next    = mode;
        pending_next = newline_pending;

        priority if (mode == nclbsd_pkg::MODE_DISCARD) begin
            // Drop everything up to and including the terminator.
            if (is_nul) begin
                mode_next    = nclbsd_pkg::MODE_NORMAL;
                pending_next = 1'b0;
            end
        end else if (newline_pending && !is_nul) begin
            // A newline must be followed directly by the terminator.
            res.emit     = 1'b1;
            res.char_out = nclbsd_pkg::CH_NUL;
            res.line_end = 1'b1;
            res.status   = nclbsd_pkg::ST_NEWLINE;
            mode_next    = nclbsd_pkg::MODE_DISCARD;
            pending_next = 1'b0;
        end else if (is_nul) begin
            // Terminator: close the line and restart the scan.
            res.emit     = 1'b1;
            res.char_out = nclbsd_pkg::CH_NUL;
            res.line_end = 1'b1;
            res.status   = (mode == nclbsd_pkg::MODE_PAREN) ? nclbsd_pkg::ST_UNCLOSED
                                                             : nclbsd_pkg::ST_OK;
            mode_next    = nclbsd_pkg::MODE_NORMAL;
            pending_next = 1'b0;
        end else if (mode == nclbsd_pkg::MODE_SEMI) begin
            res.emit = 1'b1;
        end else if (mode == nclbsd_pkg::MODE_PAREN) begin
            if (char_in == nclbsd_pkg::CH_LPAREN) begin
                res.emit     = 1'b1;
                res.char_out = nclbsd_pkg::CH_NUL;
                res.line_end = 1'b1;
                res.status   = nclbsd_pkg::ST_NESTED;
                mode_next    = nclbsd_pkg::MODE_DISCARD;
            end else begin
                res.emit = 1'b1;
                if (char_in == nclbsd_pkg::CH_RPAREN) begin
                    mode_next = nclbsd_pkg::MODE_NORMAL;
                end
            end
        end else begin
            // Normal text.
            priority if (char_in == nclbsd_pkg::CH_SEMI) begin
                res.emit  = 1'b1;
                mode_next = nclbsd_pkg::MODE_SEMI;
            end else if (is_blank) begin
                res.emit = 1'b0;
            end else if (char_in == nclbsd_pkg::CH_LF) begin
                pending_next = 1'b1;
            end else if (is_upper) begin
                res.emit     = 1'b1;
                res.char_out = char_in + nclbsd_pkg::CASE_OFFSET;
            end else begin
                res.emit = 1'b1;
                if (char_in == nclbsd_pkg::CH_LPAREN) begin
                    mode_next = nclbsd_pkg::MODE_PAREN;
                end
            end
        end
    end

endmodule
